/* rtl/core/vmu_pkg.sv */
// ----------------------------------------------------------------------------
// vmu_pkg
// Shared types and constants of the Q16.16 vector math unit.
// ----------------------------------------------------------------------------
package vmu_pkg;

  // Fixed point format
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;                // component width
  localparam int PW        = 2 * DW;            // exact product width
  localparam int TW        = PW - FRAC_BITS;    // product after the fraction shift
  localparam int SW        = TW + 2;            // sum of four shifted products
  localparam int SH        = DW - FRAC_BITS;    // divider pre-shift
  localparam int RW        = DW + 2;            // square root remainder width
  localparam int STEPS     = DW;                // sqrt / divide iterations, one per stage
  localparam int NSLOT     = 16;                // multiplier slots, row i, slot g

  localparam logic [DW-1:0] ONE     = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_SCALE = 4'd3,
    OP_CROSS = 4'd4,
    OP_NORM  = 4'd5,
    OP_DOT   = 4'd6,
    OP_XFORM = 4'd7,
    OP_LOAD  = 4'd8
  } op_e;

  // Data that rides along the whole pipeline
  typedef struct packed {
    logic [3:0][DW-1:0] rows;   // finished results of all non-normalize ops
    logic [3:0][DW-1:0] a;      // first vector, for pass-through and divide
    logic [3:0]         pass;   // component passes a
    logic               norm;   // item is a normalize
  } side_t;

endpackage

/* rtl/core/vector_math_unit_top.sv */
// ----------------------------------------------------------------------------
// vector_math_unit_top
// Pipelined Q16.16 vector ALU: add, sub, mul, scale, cross, normalize, dot,
// 4x4 transform and matrix load.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel: tuser carries opcode and matrix
//   column group, tdata carries vectors a and b. Each item gives exactly one
//   transaction on m_axis: r0..r3 in tdata and the zero-length flag in tuser.
//   A load writes the matrix as it is accepted, so any later transform sees it.
//   cfg_we_i/cfg_wdata_i write vector_size; write it only while the unit is
//   empty.
// Timing:
//   Every item runs the same path from acceptance to m_axis_tvalid_o for all
//   opcodes, so order is kept. One item is accepted per cycle while the output
//   does not stall. The length is set by the normalize path: 32 square root
//   stages and 32 divide stages, one result bit each, behind the input, multiply and sum stages.
// Reset:
//   Clears all valid bits, the matrix and sets vector_size to 4.
// Stall:
//   When the output register holds a transaction that is not taken, the whole
//   pipeline holds and s_axis_tready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector_math_unit_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i,       // vector_size
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [255:0] s_axis_tdata_i,    // a0, a1, a2, a3, b0, b1, b2, b3
  input  logic [5:0]   s_axis_tuser_i,    // opcode[3:0], column_index[5:4]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,    // r0, r1, r2, r3
  output logic [0:0]   m_axis_tuser_o     // zero_length
);

  localparam int DW    = vmu_pkg::DW;
  localparam int STEPS = vmu_pkg::STEPS;

  logic en;
  logic accept;

  // Configuration and matrix storage
  logic [2:0]               vsize_q;
  logic [15:0][DW-1:0]      mtx_q;

  // Stage 1: input register
  logic                     s1_v_q;
  logic [3:0]               s1_op_q;
  logic [3:0][DW-1:0]       s1_a_q, s1_b_q;
  vmu_pkg::side_t           s1_side_q;
  vmu_pkg::side_t           s1_side_d;

  // Stage 2: products
  logic                     s2_v_q;
  logic signed [vmu_pkg::PW-1:0] s2_prod_q [vmu_pkg::NSLOT];
  logic [vmu_pkg::NSLOT-1:0]     s2_neg_q;
  vmu_pkg::side_t           s2_side_q;

  // Stage 3: row sums and sum of squares
  logic                     s3_v_q;
  logic signed [vmu_pkg::SW-1:0] s3_row_q [4];
  logic [vmu_pkg::PW-1:0]   s3_sq_q;
  vmu_pkg::side_t           s3_side_q;

  // Square root pipeline, index 0 holds saturated rows and the radicand
  logic                     sq_v_q    [STEPS+1];
  logic [vmu_pkg::PW-1:0]   sq_x_q    [STEPS+1];
  logic [vmu_pkg::RW-1:0]   sq_rem_q  [STEPS+1];
  logic [DW-1:0]            sq_root_q [STEPS+1];
  vmu_pkg::side_t           sq_side_q [STEPS+1];

  // Divide pipeline, four lanes sharing the magnitude
  logic                     dv_v_q    [STEPS+1];
  logic [3:0][DW-1:0]       dv_rem_q  [STEPS+1];
  logic [3:0][DW-1:0]       dv_d_q    [STEPS+1];
  logic [3:0][DW-1:0]       dv_q_q    [STEPS+1];
  logic [3:0]               dv_ovf_q  [STEPS+1];
  logic [3:0]               dv_neg_q  [STEPS+1];
  logic [DW-1:0]            dv_m_q    [STEPS+1];
  vmu_pkg::side_t           dv_side_q [STEPS+1];

  // Output register
  logic                     out_v_q;
  logic [127:0]             out_data_q;
  logic                     out_zl_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsize_q <= 3'd4;
    end else if (cfg_we_i) begin
      vsize_q <= cfg_wdata_i;
    end
  end

  // Matrix load at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtx_q <= '0;
    end else if (accept && s_axis_tuser_i[3:0] == vmu_pkg::OP_LOAD) begin
      for (int i = 0; i < 4; i++) begin
        mtx_q[{s_axis_tuser_i[5:4], 2'(i)}] <= s_axis_tdata_i[(4+i)*DW +: DW];
      end
    end
  end

  // Entry: pass-through mask from the clamped vector size
  always_comb begin
    s1_side_d      = '0;
    s1_side_d.a    = s_axis_tdata_i[4*DW-1:0];
    s1_side_d.norm = s_axis_tuser_i[3:0] == vmu_pkg::OP_NORM;
    if (s_axis_tuser_i[3:0] <= vmu_pkg::OP_SCALE || s1_side_d.norm) begin
      s1_side_d.pass[2] = vsize_q <= 3'd2;
      s1_side_d.pass[3] = vsize_q <= 3'd3;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= s_axis_tuser_i[3:0];
      s1_a_q    <= s_axis_tdata_i[4*DW-1:0];
      s1_b_q    <= s_axis_tdata_i[8*DW-1:4*DW];
      s1_side_q <= s1_side_d;
    end
  end

  // Operand selection for the sixteen multipliers
  logic signed [DW-1:0] opx [vmu_pkg::NSLOT];
  logic signed [DW-1:0] opy [vmu_pkg::NSLOT];
  logic [vmu_pkg::NSLOT-1:0] opneg;

  always_comb begin
    for (int s = 0; s < vmu_pkg::NSLOT; s++) begin
      opx[s] = '0;
      opy[s] = '0;
    end
    opneg = '0;
    case (s1_op_q) inside
      vmu_pkg::OP_ADD, vmu_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          opx[i*4] = s1_a_q[i];
          opy[i*4] = vmu_pkg::ONE;
          if (!s1_side_q.pass[i]) begin
            opx[i*4+1]   = s1_b_q[i];
            opy[i*4+1]   = vmu_pkg::ONE;
            opneg[i*4+1] = s1_op_q == vmu_pkg::OP_SUB;
          end
        end
      end
      vmu_pkg::OP_MUL: begin
        for (int i = 0; i < 4; i++) begin
          opx[i*4] = s1_a_q[i];
          opy[i*4] = s1_side_q.pass[i] ? vmu_pkg::ONE : s1_b_q[i];
        end
      end
      vmu_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          opx[i*4] = s1_a_q[i];
          opy[i*4] = s1_side_q.pass[i] ? vmu_pkg::ONE : s1_b_q[0];
        end
      end
      vmu_pkg::OP_CROSS: begin
        opx[0]  = s1_a_q[1]; opy[0]  = s1_b_q[2];
        opx[1]  = s1_b_q[1]; opy[1]  = s1_a_q[2]; opneg[1] = 1'b1;
        opx[4]  = s1_b_q[0]; opy[4]  = s1_a_q[2];
        opx[5]  = s1_a_q[0]; opy[5]  = s1_b_q[2]; opneg[5] = 1'b1;
        opx[8]  = s1_a_q[0]; opy[8]  = s1_b_q[1];
        opx[9]  = s1_b_q[0]; opy[9]  = s1_a_q[1]; opneg[9] = 1'b1;
        opx[12] = s1_a_q[3]; opy[12] = vmu_pkg::ONE;
      end
      vmu_pkg::OP_NORM: begin
        // exact squares for the magnitude
        for (int g = 0; g < 3; g++) begin
          opx[g] = s1_a_q[g];
          opy[g] = s1_a_q[g];
        end
      end
      vmu_pkg::OP_DOT: begin
        for (int g = 0; g < 3; g++) begin
          opx[g] = s1_a_q[g];
          opy[g] = s1_b_q[g];
        end
      end
      vmu_pkg::OP_XFORM: begin
        for (int i = 0; i < 4; i++) begin
          for (int g = 0; g < 4; g++) begin
            opx[i*4+g] = mtx_q[g*4+i];
            opy[i*4+g] = s1_a_q[g];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 2: multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < vmu_pkg::NSLOT; s++) begin
        s2_prod_q[s] <= opx[s] * opy[s];
      end
      s2_neg_q  <= opneg;
      s2_side_q <= s1_side_q;
    end
  end

  // Stage 3: floor shift and signed row sums; unshifted sum of squares
  logic signed [vmu_pkg::SW-1:0] row_sum [4];
  logic signed [vmu_pkg::TW-1:0] term;

  always_comb begin
    term = '0;
    for (int i = 0; i < 4; i++) begin
      row_sum[i] = '0;
      for (int g = 0; g < 4; g++) begin
        term = vmu_pkg::TW'(s2_prod_q[i*4+g] >>> vmu_pkg::FRAC_BITS);
        if (s2_neg_q[i*4+g]) begin
          row_sum[i] = row_sum[i] - vmu_pkg::SW'(term);
        end else begin
          row_sum[i] = row_sum[i] + vmu_pkg::SW'(term);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s3_row_q[i] <= row_sum[i];
      end
      s3_sq_q   <= s2_prod_q[0] + s2_prod_q[1] + s2_prod_q[2];
      s3_side_q <= s2_side_q;
    end
  end

  // Saturation into the head of the square root pipeline
  vmu_pkg::side_t sat_side;

  always_comb begin
    sat_side = s3_side_q;
    for (int i = 0; i < 4; i++) begin
      if (s3_row_q[i][vmu_pkg::SW-1:DW-1] == '0 || s3_row_q[i][vmu_pkg::SW-1:DW-1] == '1) begin
        sat_side.rows[i] = s3_row_q[i][DW-1:0];
      end else if (s3_row_q[i][vmu_pkg::SW-1]) begin
        sat_side.rows[i] = vmu_pkg::MIN_NEG;
      end else begin
        sat_side.rows[i] = vmu_pkg::MAX_POS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x_q[0]    <= s3_sq_q;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_side_q[0] <= sat_side;
    end
  end

  // Square root: one result bit per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_sqrt
    logic [vmu_pkg::RW+1:0] rem2;
    logic [vmu_pkg::RW+1:0] trial;
    logic                   ge;

    assign rem2  = {sq_rem_q[k-1], sq_x_q[k-1][vmu_pkg::PW-1 -: 2]};
    assign trial = {2'b00, sq_root_q[k-1], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= sq_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_x_q[k]    <= sq_x_q[k-1] << 2;
        sq_rem_q[k]  <= ge ? vmu_pkg::RW'(rem2 - trial) : rem2[vmu_pkg::RW-1:0];
        sq_root_q[k] <= {sq_root_q[k-1][DW-2:0], ge};
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // Divider setup: magnitudes, overflow test, first partial remainder
  logic [DW-1:0]      dvi_m;
  logic [3:0][DW-1:0] dvi_u;
  logic [3:0][DW-1:0] dvi_rem, dvi_d;
  logic [3:0]         dvi_ovf, dvi_neg;

  always_comb begin
    dvi_m = sq_root_q[STEPS];
    for (int j = 0; j < 4; j++) begin
      dvi_neg[j] = sq_side_q[STEPS].a[j][DW-1];
      dvi_u[j]   = dvi_neg[j] ? -sq_side_q[STEPS].a[j] : sq_side_q[STEPS].a[j];
      dvi_rem[j] = dvi_u[j] >> vmu_pkg::SH;
      dvi_d[j]   = dvi_u[j] << vmu_pkg::FRAC_BITS;
      dvi_ovf[j] = dvi_rem[j] >= dvi_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0]  <= dvi_rem;
      dv_d_q[0]    <= dvi_d;
      dv_q_q[0]    <= '0;
      dv_ovf_q[0]  <= dvi_ovf;
      dv_neg_q[0]  <= dvi_neg;
      dv_m_q[0]    <= dvi_m;
      dv_side_q[0] <= sq_side_q[STEPS];
    end
  end

  // Restoring divide: one quotient bit per stage in each lane
  for (genvar k = 1; k <= STEPS; k++) begin : g_div
    logic [3:0][DW-1:0] rem_n, q_n;

    for (genvar j = 0; j < 4; j++) begin : g_lane
      logic [DW:0] rem2;
      logic        ge;

      assign rem2     = {dv_rem_q[k-1][j], dv_d_q[k-1][j][DW-1]};
      assign ge       = rem2 >= {1'b0, dv_m_q[k-1]};
      assign rem_n[j] = ge ? DW'(rem2 - {1'b0, dv_m_q[k-1]}) : rem2[DW-1:0];
      assign q_n[j]   = {dv_q_q[k-1][j][DW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (en) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k] <= rem_n;
        dv_q_q[k]   <= q_n;
        for (int j = 0; j < 4; j++) begin
          dv_d_q[k][j] <= dv_d_q[k-1][j] << 1;
        end
        dv_ovf_q[k]  <= dv_ovf_q[k-1];
        dv_neg_q[k]  <= dv_neg_q[k-1];
        dv_m_q[k]    <= dv_m_q[k-1];
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // Final select: signed saturated quotient, pass-through or plain result
  logic [127:0] fin_data;
  logic         fin_zero;
  logic [DW-1:0] fin_q;

  always_comb begin
    fin_zero = dv_m_q[STEPS] == '0;
    fin_data = '0;
    fin_q    = '0;
    for (int j = 0; j < 4; j++) begin
      if (dv_neg_q[STEPS][j]) begin
        if (dv_ovf_q[STEPS][j] || dv_q_q[STEPS][j] > vmu_pkg::MIN_NEG) begin
          fin_q = vmu_pkg::MIN_NEG;
        end else begin
          fin_q = -dv_q_q[STEPS][j];
        end
      end else begin
        if (dv_ovf_q[STEPS][j] || dv_q_q[STEPS][j][DW-1]) begin
          fin_q = vmu_pkg::MAX_POS;
        end else begin
          fin_q = dv_q_q[STEPS][j];
        end
      end
      if (!dv_side_q[STEPS].norm) begin
        fin_data[j*DW +: DW] = dv_side_q[STEPS].rows[j];
      end else if (dv_side_q[STEPS].pass[j]) begin
        fin_data[j*DW +: DW] = dv_side_q[STEPS].a[j];
      end else if (!fin_zero) begin
        fin_data[j*DW +: DW] = fin_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= fin_data;
      out_zl_q   <= dv_side_q[STEPS].norm && fin_zero;
    end
  end

  assign m_axis_tvalid_o   = out_v_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_zl_q;

endmodule

/* test/vector_math_unit_top_test.sv */
// ----------------------------------------------------------------------------
// vector_math_unit_top_test
// Self-checking bench for the Q16.16 vector unit. Items go in on the slave
// stream with random gaps, results are checked in order against a predictor
// of every opcode, including saturation, normalize and the stored matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector_math_unit_top_test;

  typedef struct {
    logic [3:0]         opcode;
    logic [1:0]         column;
    logic [3:0][31:0]   a;
    logic [3:0][31:0]   b;
  } vec_item_t;

  typedef struct {
    logic [3:0][31:0]   r;
    logic               zero_length;
  } vec_result_t;

  // Clock, reset and stimulus signals
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [255:0] s_axis_tdata_i = '0;
  logic [5:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  // Predictor state and scoreboard
  logic [31:0]  matrix_words [16];
  logic [2:0]   size_reg;
  vec_result_t  pending_results [$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           results_seen = 0;
  int           hold_left = 0;
  bit           busy_mode = 1'b0;   // no gaps on either side while set

  always #1 clk_i = ~clk_i;

  vector_math_unit_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Fixed point helpers
  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // exact product, then floor shift
  function automatic longint qmul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> vmu_pkg::FRAC_BITS;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] norm_div(longint v, logic [63:0] mag);
    logic [63:0] u, q;
    u = (v < 0) ? 64'(-v) : 64'(v);
    q = (u << vmu_pkg::FRAC_BITS) / mag;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    return clamp32((v < 0) ? -longint'(q) : longint'(q));
  endfunction

  // Computes the result of one accepted item and updates the matrix copy
  function automatic vec_result_t compute_vector_op(vec_item_t it);
    vec_result_t res;
    longint      a [4];
    longint      b [4];
    longint      acc;
    logic [63:0] mag;
    int          n;
    n = (size_reg < 2) ? 2 : (size_reg > 4) ? 4 : int'(size_reg);
    for (int i = 0; i < 4; i++) begin
      a[i] = sext(it.a[i]);
      b[i] = sext(it.b[i]);
      res.r[i] = '0;
    end
    res.zero_length = 1'b0;
    case (it.opcode) inside
      vmu_pkg::OP_ADD, vmu_pkg::OP_SUB, vmu_pkg::OP_MUL, vmu_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          if (i >= n) res.r[i] = it.a[i];
          else if (it.opcode == vmu_pkg::OP_ADD) res.r[i] = clamp32(a[i] + b[i]);
          else if (it.opcode == vmu_pkg::OP_SUB) res.r[i] = clamp32(a[i] - b[i]);
          else if (it.opcode == vmu_pkg::OP_MUL) res.r[i] = clamp32(qmul(a[i], b[i]));
          else res.r[i] = clamp32(qmul(a[i], b[0]));
        end
      end
      vmu_pkg::OP_CROSS: begin
        res.r[0] = clamp32(qmul(a[1], b[2]) - qmul(b[1], a[2]));
        res.r[1] = clamp32(qmul(b[0], a[2]) - qmul(a[0], b[2]));
        res.r[2] = clamp32(qmul(a[0], b[1]) - qmul(b[0], a[1]));
        res.r[3] = it.a[3];
      end
      vmu_pkg::OP_NORM: begin
        mag = int_sqrt(64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]));
        res.zero_length = (mag == 0);
        for (int i = 0; i < 4; i++) begin
          if (i >= n) res.r[i] = it.a[i];
          else if (mag != 0) res.r[i] = norm_div(a[i], mag);
        end
      end
      vmu_pkg::OP_DOT:
        res.r[0] = clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
      vmu_pkg::OP_XFORM: begin
        for (int i = 0; i < 4; i++) begin
          acc = 0;
          for (int g = 0; g < 4; g++) acc += qmul(sext(matrix_words[g*4+i]), a[g]);
          res.r[i] = clamp32(acc);
        end
      end
      vmu_pkg::OP_LOAD: for (int i = 0; i < 4; i++) matrix_words[it.column*4+i] = it.b[i];
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Sends one item and queues its expected result on acceptance
  task automatic send_item(vec_item_t it);
    int gap;
    gap = busy_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i = {it.b, it.a};
    s_axis_tuser_i = {it.column, it.opcode};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(compute_vector_op(it));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_size(logic [2:0] v);
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    size_reg = v;
  endtask

  function automatic vec_item_t make_item(logic [3:0] op, int col,
                                          logic [3:0][31:0] a, logic [3:0][31:0] b);
    vec_item_t it;
    it.opcode = op;
    it.column = 2'(col);
    it.a = a;
    it.b = b;
    return it;
  endfunction

  // Random component: full range, small magnitude or an extreme
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5)) inside
      0, 1: return $urandom();
      2, 3: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      4:    return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    vec_item_t it;
    if ($urandom_range(0, 15) == 0) it.opcode = 4'($urandom_range(9, 15));
    else it.opcode = 4'($urandom_range(vmu_pkg::OP_ADD, vmu_pkg::OP_LOAD));
    it.column = 2'($urandom_range(0, 3));
    for (int i = 0; i < 4; i++) begin
      it.a[i] = rand_comp();
      it.b[i] = rand_comp();
    end
    return it;
  endfunction

  // Directed: extremes of add/sub/mul/scale, cross, dot, unused opcode
  task automatic test_arith_edges();
    logic [3:0][31:0] mx, mn, one, z;
    mx = {4{32'h7fff_ffff}};
    mn = {4{32'h8000_0000}};
    one = {4{32'h0001_0000}};
    z = '0;
    send_item(make_item(vmu_pkg::OP_ADD, 0, mx, mx));
    send_item(make_item(vmu_pkg::OP_ADD, 0, mn, mn));
    send_item(make_item(vmu_pkg::OP_SUB, 0, mn, mx));
    send_item(make_item(vmu_pkg::OP_SUB, 0, mx, mn));
    send_item(make_item(vmu_pkg::OP_MUL, 0, mx, mx));
    send_item(make_item(vmu_pkg::OP_MUL, 0, mn, mx));
    send_item(make_item(vmu_pkg::OP_MUL, 0, {4{32'hffff_ffff}}, one));
    send_item(make_item(vmu_pkg::OP_SCALE, 0, mn, mn));
    send_item(make_item(vmu_pkg::OP_CROSS, 0, mx, mn));
    send_item(make_item(vmu_pkg::OP_CROSS, 0, {32'h5, 32'h0, 32'h0, 32'h0001_0000},
                                              {32'h0, 32'h0, 32'h0001_0000, 32'h0}));
    send_item(make_item(vmu_pkg::OP_DOT, 0, mx, mx));
    send_item(make_item(vmu_pkg::OP_DOT, 0, mn, mx));
    send_item(make_item(4'hf, 3, mx, mn));
    send_item(make_item(4'h9, 0, one, z));
    wait_drained();
  endtask

  // Directed: zero vector and extremes of normalize
  task automatic test_normalize();
    send_item(make_item(vmu_pkg::OP_NORM, 0, {32'h1234, 32'h0, 32'h0, 32'h0}, '0));
    send_item(make_item(vmu_pkg::OP_NORM, 0, {32'h0, 32'h0, 32'h0, 32'h8000_0000}, '0));
    send_item(make_item(vmu_pkg::OP_NORM, 0, {32'h0, 32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000}, '0));
    send_item(make_item(vmu_pkg::OP_NORM, 0, {32'h7fff_ffff, 32'h0, 32'h0, 32'h1}, '0));
    send_item(make_item(vmu_pkg::OP_NORM, 0, {32'h0, 32'h7fff_ffff, 32'hffff_ffff,
                                              32'h0000_0001}, '0));
    wait_drained();
  endtask

  // Directed: load all four groups, then transform
  task automatic test_transform();
    for (int g = 0; g < 4; g++)
      send_item(make_item(vmu_pkg::OP_LOAD, g, '0,
                {32'h0001_0000 * (g + 1), 32'h8000_0000, 32'h7fff_ffff,
                 32'h0001_0000 << g}));
    send_item(make_item(vmu_pkg::OP_XFORM, 0, {32'h0001_0000, 32'hffff_0000,
                                               32'h0002_0000, 32'h0000_8000}, '0));
    send_item(make_item(vmu_pkg::OP_XFORM, 0, {4{32'h7fff_ffff}}, '0));
    wait_drained();
  endtask

  // Random mix under each vector size setting, extremes included
  task automatic test_random_sizes(int count);
    logic [2:0] sizes [8] = '{3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd1, 3'd5, 3'd6};
    for (int s = 0; s < 8; s++) begin
      write_size(sizes[s]);
      busy_mode = (s == 3);
      for (int k = 0; k < count; k++) send_item(rand_item());
      busy_mode = 1'b0;
      wait_drained();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the unit fills up
  task automatic test_backpressure();
    hold_left = 300;
    busy_mode = 1'b1;
    for (int k = 0; k < 100; k++) send_item(rand_item());
    busy_mode = 1'b0;
    wait_drained();
  endtask

  // Result side: random stall per transaction plus the long hold
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        stall_left = busy_mode ? 0 : $urandom_range(0, 3);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    vec_result_t want;
    logic [3:0][31:0] got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction r0", got[0], '0);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 4; i++)
          if (got[i] !== want.r[i]) report_mismatch($sformatf("r%0d", i), got[i], want.r[i]);
        if (m_axis_tuser_o[0] !== want.zero_length)
          report_mismatch("zero_length", 32'(m_axis_tuser_o), 32'(want.zero_length));
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < 16; i++) matrix_words[i] = '0;
    size_reg = 3'd4;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_arith_edges();
    test_normalize();
    write_size(3'd2);
    test_transform();
    test_random_sizes(35);
    test_backpressure();
    wait_drained();
    repeat (80) @(negedge clk_i);
    $display("covered %0d items and %0d results: all opcodes, vector sizes 0..7,",
             items_sent, results_seen);
    $display("saturation, zero-length normalize, matrix loads and a long output stall");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/vmu_pkg.sv
rtl/core/vector_math_unit_top.sv
test/vector_math_unit_top_test.sv
